### design/linear_scan_point_store_defines.svh
// Assertion macros for the linear scan point store checker.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef LINEAR_SCAN_POINT_STORE_DEFINES_SVH
`define LINEAR_SCAN_POINT_STORE_DEFINES_SVH

`define LSPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsps: property violated");

`define LSPS_ASSERT_IMP(lbl, ante, cons) \
  `LSPS_ASSERT(lbl, (ante) |-> (cons))

`define LSPS_ASSERT_NEXT(lbl, ante, cons) \
  `LSPS_ASSERT(lbl, (ante) |=> (cons))

`endif

### design/lsps_pkg.sv
// Types and codes for the linear scan point store.
// No dependencies.
package lsps_pkg;

  localparam int IN_DIMS  = 3;
  localparam int FIELD_W  = 32;
  localparam int MCOUNT_W = 6;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_EXISTS = 3'd3,
    CMD_BOX    = 3'd4,
    CMD_CLEAR  = 3'd5
  } lsps_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ERASE
  } lsps_state_e;

  typedef struct packed {
    logic [2:0]                cmd;
    logic signed [FIELD_W-1:0] point_a_0;
    logic signed [FIELD_W-1:0] point_a_1;
    logic signed [FIELD_W-1:0] point_a_2;
    logic signed [FIELD_W-1:0] point_b_0;
    logic signed [FIELD_W-1:0] point_b_1;
    logic signed [FIELD_W-1:0] point_b_2;
  } lsps_item_t;

  typedef struct packed {
    logic                      kind;
    logic                      ok;
    logic [MCOUNT_W-1:0]       match_count;
    logic signed [FIELD_W-1:0] out_coord_0;
    logic signed [FIELD_W-1:0] out_coord_1;
    logic signed [FIELD_W-1:0] out_coord_2;
    logic                      last;
  } lsps_result_t;

endpackage

### design/linear_scan_point_store.sv
// Linear scan point store: point set with insert/remove/update/exists/box/clear.
// Depends on lsps_pkg.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  command  | start, busy               | item_i (lsps_item_t)
//  config   | cfg_we_i                  | cfg_wdata_i (dims_in_use)
//  result   | result_valid_o (strobe)   | result_o (lsps_result_t)
//
// One transaction scans the stored entries through the single memory read
// port and the shared compare unit, holding busy until the scan is done.
// An update that erases adds a compaction pass that shifts the later entries down.
// Reset clears the count; the entry memory needs no clearing.
// Results are one-cycle strobes, one item per cycle at most; no stalls.
module linear_scan_point_store #(
  parameter int STORE_DEPTH = 32,
  parameter int MAX_DIMS    = 3,
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  lsps_pkg::lsps_item_t item_i,
  output logic                 busy,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  output logic                 result_valid_o,
  output lsps_pkg::lsps_result_t result_o
);
  import lsps_pkg::*;

  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] entry_t;

  lsps_state_e state_q, state_d;

  logic [2:0]       cmd_q;
  logic [1:0]       dims_q;
  entry_t           a_q, b_q;
  logic [CNT_W-1:0] cnt_q, rd_q, wr_q, n_q;
  logic [IDX_W-1:0] p_idx_q, pos_q;
  logic             p_vld_q, hit_q, hitb_q;

  entry_t           mem [STORE_DEPTH];
  entry_t           rdata_q;

  logic             out_vld_q;
  lsps_result_t     out_q;

  // input coordinates, truncated to COORD_WIDTH
  logic [IN_DIMS-1:0][FIELD_W-1:0] in_a, in_b;
  entry_t                          a_in, b_in;

  logic [1:0]          act_dims;
  logic [IN_DIMS-1:0]  use_dim;
  logic                eq_a, eq_b, in_box, ab_same;
  logic                issue, scan_done, upd_erase, st_ok, ins_ok;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;
  logic [IN_DIMS-1:0][FIELD_W-1:0] rd_ext, pt_coord;

  assign in_a = {item_i.point_a_2, item_i.point_a_1, item_i.point_a_0};
  assign in_b = {item_i.point_b_2, item_i.point_b_1, item_i.point_b_0};

  always_comb begin
    for (int j = 0; j < MAX_DIMS; j++) begin
      a_in[j] = in_a[j][COORD_WIDTH-1:0];
      b_in[j] = in_b[j][COORD_WIDTH-1:0];
    end
  end

  always_comb begin
    if (dims_q == 2'd0) begin
      act_dims = 2'd1;
    end else if (dims_q > 2'(MAX_DIMS)) begin
      act_dims = 2'(MAX_DIMS);
    end else begin
      act_dims = dims_q;
    end
    for (int j = 0; j < IN_DIMS; j++) begin
      use_dim[j] = 2'(j) < act_dims;
    end
  end

  // shared compare unit: one stored entry against the operands per cycle
  always_comb begin
    eq_a    = 1'b1;
    eq_b    = 1'b1;
    in_box  = 1'b1;
    ab_same = 1'b1;
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (use_dim[j]) begin
        if (rdata_q[j] != a_q[j]) eq_a = 1'b0;
        if (rdata_q[j] != b_q[j]) eq_b = 1'b0;
        if ($signed(rdata_q[j]) < $signed(a_q[j]) ||
            $signed(rdata_q[j]) > $signed(b_q[j])) in_box = 1'b0;
        if (a_q[j] != b_q[j]) ab_same = 1'b0;
      end
    end
  end

  assign busy      = (state_q != ST_IDLE);
  assign issue     = busy && (rd_q < cnt_q);
  assign scan_done = busy && !issue && !p_vld_q;
  assign ins_ok    = !hit_q && (cnt_q < CNT_W'(STORE_DEPTH));
  assign upd_erase = (cmd_q == CMD_UPDATE) && hit_q && !ab_same && hitb_q;

  always_comb begin
    case (cmd_q)
      CMD_INSERT:                         st_ok = ins_ok;
      CMD_REMOVE, CMD_UPDATE, CMD_EXISTS: st_ok = hit_q;
      CMD_BOX, CMD_CLEAR:                 st_ok = 1'b1;
      default:                            st_ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = upd_erase ? ST_ERASE : ST_IDLE;
      end
      ST_ERASE: begin
        if (scan_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory write control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_q[IDX_W-1:0];
    wr_data = rdata_q;
    case (state_q)
      ST_SCAN: begin
        if (p_vld_q && cmd_q == CMD_REMOVE && !eq_a) begin
          wr_en = 1'b1;
        end else if (scan_done && cmd_q == CMD_INSERT && ins_ok) begin
          wr_en   = 1'b1;
          wr_addr = cnt_q[IDX_W-1:0];
          wr_data = a_q;
        end else if (scan_done && cmd_q == CMD_UPDATE && hit_q && !ab_same && !hitb_q) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = b_q;
        end
      end
      ST_ERASE: begin
        wr_en = p_vld_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rdata_q <= mem[rd_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      a_q <= a_in;
      b_q <= b_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dims_q  <= 2'd3;
      cmd_q   <= CMD_INSERT;
      cnt_q   <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      n_q     <= '0;
      p_idx_q <= '0;
      pos_q   <= '0;
      p_vld_q <= 1'b0;
      hit_q   <= 1'b0;
      hitb_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p_vld_q <= issue;
      if (cfg_we_i) dims_q <= cfg_wdata_i;
      if (issue) begin
        rd_q    <= rd_q + CNT_W'(1);
        p_idx_q <= rd_q[IDX_W-1:0];
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q  <= item_i.cmd;
            rd_q   <= '0;
            wr_q   <= '0;
            n_q    <= '0;
            hit_q  <= 1'b0;
            hitb_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (p_vld_q) begin
            case (cmd_q)
              CMD_INSERT, CMD_EXISTS: begin
                if (eq_a) hit_q <= 1'b1;
              end
              CMD_REMOVE: begin
                if (eq_a) hit_q <= 1'b1;
                else wr_q <= wr_q + CNT_W'(1);
              end
              CMD_UPDATE: begin
                if (eq_a && !hit_q) begin
                  hit_q <= 1'b1;
                  pos_q <= p_idx_q;
                end
                if (eq_b) hitb_q <= 1'b1;
              end
              CMD_BOX: begin
                if (in_box) n_q <= n_q + CNT_W'(1);
              end
              default: ;
            endcase
          end
          if (scan_done) begin
            case (cmd_q)
              CMD_INSERT: begin
                if (ins_ok) cnt_q <= cnt_q + CNT_W'(1);
              end
              CMD_REMOVE: cnt_q <= wr_q;
              CMD_CLEAR:  cnt_q <= '0;
              CMD_UPDATE: begin
                if (upd_erase) begin
                  rd_q <= CNT_W'(pos_q) + CNT_W'(1);
                  wr_q <= CNT_W'(pos_q);
                end
              end
              default: ;
            endcase
          end
        end
        ST_ERASE: begin
          if (p_vld_q) wr_q <= wr_q + CNT_W'(1);
          if (scan_done) cnt_q <= wr_q;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_comb begin
    rd_ext = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      rd_ext[j] = FIELD_W'($signed(rdata_q[j]));
    end
    for (int j = 0; j < IN_DIMS; j++) begin
      pt_coord[j] = use_dim[j] ? rd_ext[j] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= (state_q == ST_SCAN && p_vld_q && cmd_q == CMD_BOX && in_box) ||
                   (state_q == ST_SCAN && scan_done && !upd_erase) ||
                   (state_q == ST_ERASE && scan_done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      out_q.kind        <= KIND_POINT;
      out_q.ok          <= 1'b0;
      out_q.match_count <= '0;
      out_q.out_coord_0 <= pt_coord[0];
      out_q.out_coord_1 <= pt_coord[1];
      out_q.out_coord_2 <= pt_coord[2];
      out_q.last        <= 1'b0;
    end else if (scan_done) begin
      out_q.kind        <= KIND_STATUS;
      out_q.ok          <= st_ok;
      out_q.match_count <= (cmd_q == CMD_BOX) ? MCOUNT_W'(n_q) : '0;
      out_q.out_coord_0 <= '0;
      out_q.out_coord_1 <= '0;
      out_q.out_coord_2 <= '0;
      out_q.last        <= 1'b1;
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

### design/lsps_checker.sv
// Port-level checker for the linear scan point store, bound to the top level.
// Depends on lsps_pkg and linear_scan_point_store_defines.svh.
`include "linear_scan_point_store_defines.svh"

module lsps_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_i,
  input logic                   result_valid_i,
  input lsps_pkg::lsps_result_t result_i
);
  import lsps_pkg::*;

  `LSPS_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i)
  `LSPS_ASSERT_IMP(a_result_in_txn, result_valid_i, $past(busy_i))
  `LSPS_ASSERT_IMP(a_status_last, result_valid_i && result_i.kind == KIND_STATUS, result_i.last)
  `LSPS_ASSERT_IMP(a_point_clean, result_valid_i && result_i.kind == KIND_POINT, !result_i.last && !result_i.ok && result_i.match_count == '0)
  `LSPS_ASSERT_NEXT(a_gap_after_last, result_valid_i && result_i.last, !result_valid_i)

endmodule

bind linear_scan_point_store lsps_checker u_lsps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);

### tb/sv/tb_top.sv
// Self-checking testbench for linear_scan_point_store: directed and random command
// streams under several dims settings and pacing phases, checked by a point-set tracker.
// Depends on lsps_pkg and the linear_scan_point_store RTL.
`timescale 1ns / 100ps

module tb_top;
  import lsps_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int LIMIT       = 200000;
  localparam int MAX_SHOWN   = 10;

  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef logic [IN_DIMS-1:0][FIELD_W-1:0] point_t;

  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_MAX = 32'sh7fff_ffff;

  class point_set_tracker;
    point_t       pts[STORE_DEPTH];
    int unsigned  n_pts;
    logic [1:0]   dims_reg;
    lsps_result_t pending[$];
    int unsigned  mismatches;
    int unsigned  replies;
    int unsigned  box_hits;
    int unsigned  full_refusals;

    function new();
      n_pts         = 0;
      dims_reg      = 2'd3;
      mismatches    = 0;
      replies       = 0;
      box_hits      = 0;
      full_refusals = 0;
    endfunction

    function int unsigned dims_eff();
      if (dims_reg == 2'd0) return 1;
      if (dims_reg > IN_DIMS) return IN_DIMS;
      return dims_reg;
    endfunction

    function bit same(point_t x, point_t y);
      for (int j = 0; j < dims_eff(); j++) begin
        if (x[j] !== y[j]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int find(point_t p);
      for (int i = 0; i < n_pts; i++) begin
        if (same(pts[i], p)) return i;
      end
      return -1;
    endfunction

    function void erase(int unsigned idx);
      for (int unsigned i = idx; i + 1 < n_pts; i++) pts[i] = pts[i + 1];
      n_pts--;
    endfunction

    function point_t any_stored();
      return pts[$urandom_range(0, n_pts - 1)];
    endfunction

    function void push_status(bit ok, logic [MCOUNT_W-1:0] cnt);
      lsps_result_t r;
      r             = '0;
      r.kind        = KIND_STATUS;
      r.ok          = ok;
      r.match_count = cnt;
      r.last        = 1'b1;
      pending = {pending, r};
    endfunction

    function void push_match(point_t p);
      lsps_result_t r;
      int unsigned  d;
      d             = dims_eff();
      r             = '0;
      r.kind        = KIND_POINT;
      r.out_coord_0 = p[0];
      r.out_coord_1 = (d >= 2) ? p[1] : '0;
      r.out_coord_2 = (d >= 3) ? p[2] : '0;
      pending = {pending, r};
    endfunction

    // Accepted command: update the point set and queue the replies it causes.
    function void apply_command(lsps_item_t it);
      point_t      a;
      point_t      b;
      bit          ok;
      bit          in_box;
      int          idx;
      int unsigned i;
      int unsigned hits;
      a    = {it.point_a_2, it.point_a_1, it.point_a_0};
      b    = {it.point_b_2, it.point_b_1, it.point_b_0};
      ok   = 1'b0;
      hits = 0;
      case (it.cmd)
        CMD_INSERT: begin
          if (find(a) < 0) begin
            if (n_pts < STORE_DEPTH) begin
              pts[n_pts] = a;
              n_pts++;
              ok = 1'b1;
            end else begin
              full_refusals++;
            end
          end
        end
        CMD_REMOVE: begin
          i = 0;
          while (i < n_pts) begin
            if (same(pts[i], a)) begin
              erase(i);
              ok = 1'b1;
            end else begin
              i++;
            end
          end
        end
        CMD_UPDATE: begin
          idx = find(a);
          if (idx >= 0) begin
            ok = 1'b1;
            if (!same(a, b)) begin
              if (find(b) >= 0) erase(idx);
              else pts[idx] = b;
            end
          end
        end
        CMD_EXISTS: ok = (find(a) >= 0);
        CMD_BOX: begin
          for (i = 0; i < n_pts; i++) begin
            in_box = 1'b1;
            for (int j = 0; j < dims_eff(); j++) begin
              if ($signed(pts[i][j]) < $signed(a[j]) || $signed(pts[i][j]) > $signed(b[j]))
                in_box = 1'b0;
            end
            if (in_box) begin
              push_match(pts[i]);
              hits++;
            end
          end
          box_hits += hits;
          push_status(1'b1, hits[MCOUNT_W-1:0]);
          return;
        end
        CMD_CLEAR: begin
          n_pts = 0;
          ok    = 1'b1;
        end
        default: ok = 1'b0;
      endcase
      push_status(ok, '0);
    endfunction

    function void report(string what, lsps_result_t want, lsps_result_t got);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("MISMATCH %s at %0t", what, $realtime);
        $display("  expected kind=%0b ok=%0b cnt=%0d c=(%0d,%0d,%0d) last=%0b",
                 want.kind, want.ok, want.match_count, want.out_coord_0,
                 want.out_coord_1, want.out_coord_2, want.last);
        $display("  actual   kind=%0b ok=%0b cnt=%0d c=(%0d,%0d,%0d) last=%0b",
                 got.kind, got.ok, got.match_count, got.out_coord_0,
                 got.out_coord_1, got.out_coord_2, got.last);
      end
    endfunction

    function void match_reply(lsps_result_t got);
      lsps_result_t want;
      replies++;
      if (pending.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.ok !== want.ok ||
          got.match_count !== want.match_count ||
          got.out_coord_0 !== want.out_coord_0 || got.out_coord_1 !== want.out_coord_1 ||
          got.out_coord_2 !== want.out_coord_2 || got.last !== want.last)
        report("result field", want, got);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  lsps_item_t   item_i;
  logic         busy;
  logic         cfg_we_i;
  logic [1:0]   cfg_wdata_i;
  logic         result_valid_o;
  lsps_result_t result_o;

  point_set_tracker tracker = new();
  int unsigned      cycle_cnt = 0;
  int unsigned      n_sent = 0;

  linear_scan_point_store u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) tracker.match_reply(result_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, tracker.pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic point_t pt(coord_t x0, coord_t x1, coord_t x2);
    return {x2, x1, x0};
  endfunction

  function automatic lsps_item_t mk(logic [2:0] c, point_t a, point_t b);
    lsps_item_t it;
    it.cmd       = c;
    it.point_a_0 = a[0];
    it.point_a_1 = a[1];
    it.point_a_2 = a[2];
    it.point_b_0 = b[0];
    it.point_b_1 = b[1];
    it.point_b_2 = b[2];
    return it;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return C_MIN;
      1:       return C_MAX;
      2, 3, 4, 5, 6: return coord_t'($urandom_range(0, 6)) - 3;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    return pt(rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic lsps_item_t random_cmd(int unsigned ins_pct);
    point_t      a;
    point_t      b;
    point_t      seen;
    logic [2:0]  c;
    int unsigned r;
    coord_t      lo;
    seen = (tracker.n_pts != 0) ? tracker.any_stored() : rand_point();
    a    = ($urandom_range(0, 99) < 65) ? seen : rand_point();
    b    = rand_point();
    if ($urandom_range(0, 99) < 30) a[2] = rand_coord();
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      c = CMD_INSERT;
      a = ($urandom_range(0, 99) < 10) ? seen : rand_point();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 22)      c = CMD_REMOVE;
      else if (r < 44) c = CMD_UPDATE;
      else if (r < 66) c = CMD_EXISTS;
      else if (r < 90) c = CMD_BOX;
      else if (r < 95) c = CMD_CLEAR;
      else if (r < 98) c = CMD_RSVD_6;
      else             c = CMD_RSVD_7;
    end
    if (c == CMD_UPDATE) begin
      r = $urandom_range(0, 99);
      if (r < 30 && tracker.n_pts != 0) b = tracker.any_stored();
      else if (r < 50)                  b = a;
    end
    if (c == CMD_BOX) begin
      for (int j = 0; j < IN_DIMS; j++) begin
        case ($urandom_range(0, 3))
          0: begin
            a[j] = C_MIN;
            b[j] = C_MAX;
          end
          1: begin
            a[j] = seen[j];
            b[j] = seen[j];
          end
          2: begin
            lo   = coord_t'($urandom_range(0, 6)) - 3;
            a[j] = lo;
            b[j] = lo + coord_t'($urandom_range(0, 4));
          end
          default: begin
            a[j] = rand_coord();
            b[j] = rand_coord();
          end
        endcase
      end
    end
    return mk(c, a, b);
  endfunction

  task automatic send_cmd(lsps_item_t it, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy);
    tracker.apply_command(it);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (tracker.pending.size() != 0 || busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_dims(logic [1:0] v);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    tracker.dims_reg = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [1:0]  ph_dims[4]  = '{2'd3, 2'd1, 2'd2, 2'd0};
    int unsigned ph_idle[4]  = '{0, 69, 0, 31};
    int unsigned ph_items[4] = '{50, 20, 20, 20};
    int unsigned ph_ins[4]   = '{90, 35, 35, 35};
    int unsigned n_directed;

    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 2'd3;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty store, extremes, every command and each special case
    send_cmd(mk(CMD_EXISTS, pt(0, 0, 0), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_BOX, pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX)), 0);
    send_cmd(mk(CMD_INSERT, pt(C_MIN, C_MIN, C_MIN), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_INSERT, pt(C_MAX, C_MAX, C_MAX), pt(C_MIN, C_MIN, C_MIN)), 0);
    send_cmd(mk(CMD_INSERT, pt(0, -1, 1), pt(C_MAX, C_MAX, C_MAX)), 0);
    send_cmd(mk(CMD_INSERT, pt(C_MAX, C_MAX, C_MAX), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_EXISTS, pt(C_MAX, C_MAX, C_MAX), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_BOX, pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX)), 0);
    send_cmd(mk(CMD_BOX, pt(1, C_MIN, C_MIN), pt(0, C_MAX, C_MAX)), 0);
    send_cmd(mk(CMD_BOX, pt(-1, -1, -1), pt(0, 0, 1)), 0);
    send_cmd(mk(CMD_UPDATE, pt(5, 5, 5), pt(6, 6, 6)), 0);
    send_cmd(mk(CMD_UPDATE, pt(0, -1, 1), pt(0, -1, 1)), 0);
    send_cmd(mk(CMD_UPDATE, pt(0, -1, 1), pt(C_MAX, C_MAX, C_MAX)), 0);
    send_cmd(mk(CMD_UPDATE, pt(C_MIN, C_MIN, C_MIN), pt(7, 8, 9)), 0);
    send_cmd(mk(CMD_REMOVE, pt(7, 8, 9), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_REMOVE, pt(7, 8, 9), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_RSVD_6, pt(C_MAX, C_MAX, C_MAX), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_RSVD_7, pt(0, 0, 0), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_CLEAR, pt(0, 0, 0), pt(0, 0, 0)), 0);
    send_cmd(mk(CMD_BOX, pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX)), 0);
    send_cmd(mk(CMD_INSERT, pt(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555),
                pt(32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'shaaaa_aaaa)), 0);
    send_cmd(mk(CMD_INSERT, pt(32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'shaaaa_aaaa),
                pt(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555)), 0);
    n_directed = n_sent;

    // random phases; the store is not cleared between them so that a lower
    // dims setting sees entries that now compare equal
    for (int p = 0; p < 4; p++) begin
      write_dims(ph_dims[p]);
      for (int k = 0; k < ph_items[p]; k++) begin
        if (k == 15) wait_idle();
        send_cmd(random_cmd(ph_ins[p]), ph_idle[p]);
      end
    end

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (tracker.pending.size() != 0) begin
      $display("%0d expected results never arrived", tracker.pending.size());
      tracker.mismatches += tracker.pending.size();
    end

    $display("Ran %0d commands (%0d directed) with dims 3, 1, 2 and 0 under four pacing phases.",
             n_sent, n_directed);
    $display("Checked %0d results: %0d box matches, %0d inserts refused on a full store.",
             tracker.replies, tracker.box_hits, tracker.full_refusals);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
